// ----- hw/rtl/sfpp_pkg.sv -----
// Shared types, codes and the mod-255 sum helper for the sync-framed packet parser.
// No dependencies; imported by sfpp_parser and the top level.
package sfpp_pkg;

  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_CLASS   = 3'd2;
  localparam logic [2:0] PH_ID      = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHK1    = 3'd6;
  localparam logic [2:0] PH_CHK2    = 3'd7;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SUM_START   = 8'hFF;
  localparam logic [7:0] SYNC1_RESET = 8'hC2;
  localparam logic [7:0] SYNC2_RESET = 8'h53;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] class_code;
    logic [7:0] msg_id;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } result_t;

  // One-step add kept mod 255: subtract 255 once when the sum passes 255
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

// ----- hw/rtl/sfpp_parser.sv -----
// Frame state machine, captured header fields and running Fletcher sums.
// Depends on sfpp_pkg; one byte is processed per cycle when step is high.
module sfpp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        sync_first,
  input  logic [7:0]        sync_second,
  output logic              has_result,
  output sfpp_pkg::result_t result
);
  import sfpp_pkg::*;

  logic [2:0] phase, phase_next;
  logic [7:0] frame_class, frame_class_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] sum_low, sum_low_next;
  logic [7:0] sum_high, sum_high_next;

  logic [7:0] fold_low, fold_high;
  logic [7:0] seed_low, seed_high;
  logic [7:0] count_inc;

  // Fold into the running sums, and fold into freshly restarted sums
  assign fold_low  = add_mod255(sum_low, rx_byte);
  assign fold_high = add_mod255(sum_high, fold_low);
  assign seed_low  = add_mod255(SUM_START, rx_byte);
  assign seed_high = add_mod255(SUM_START, seed_low);
  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    frame_class_next   = frame_class;
    frame_id_next      = frame_id;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    sum_low_next       = sum_low;
    sum_high_next      = sum_high;
    has_result         = 1'b0;
    result             = '{kind: KIND_PAYLOAD, class_code: frame_class, msg_id: frame_id,
                           payload_len: frame_length, payload_byte: 8'd0,
                           payload_index: 8'd0};
    unique case (phase)
      PH_SYNC1: begin
        if (rx_byte == sync_first) begin
          sum_low_next  = fold_low;
          sum_high_next = fold_high;
          phase_next    = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == sync_second) begin
          sum_low_next  = fold_low;
          sum_high_next = fold_high;
          phase_next    = PH_CLASS;
        end else if (rx_byte == sync_first) begin
          // restart the hunt seeded with this sync byte
          sum_low_next  = seed_low;
          sum_high_next = seed_high;
        end else begin
          sum_low_next  = SUM_START;
          sum_high_next = SUM_START;
          phase_next    = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        frame_class_next = rx_byte;
        sum_low_next     = fold_low;
        sum_high_next    = fold_high;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum_low_next  = fold_low;
        sum_high_next = fold_high;
        phase_next    = PH_LENGTH;
      end
      PH_LENGTH: begin
        frame_length_next  = rx_byte;
        sum_low_next       = fold_low;
        sum_high_next      = fold_high;
        payload_count_next = 8'd0;
        phase_next         = (rx_byte == 8'd0) ? PH_CHK1 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        has_result           = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = payload_count;
        sum_low_next         = fold_low;
        sum_high_next        = fold_high;
        if (count_inc == frame_length) begin
          payload_count_next = 8'd0;
          phase_next         = PH_CHK1;
        end else begin
          payload_count_next = count_inc;
        end
      end
      PH_CHK1: begin
        if (rx_byte == sum_low) begin
          phase_next = PH_CHK2;
        end else begin
          has_result    = 1'b1;
          result.kind   = KIND_BAD;
          sum_low_next  = SUM_START;
          sum_high_next = SUM_START;
          phase_next    = PH_SYNC1;
        end
      end
      PH_CHK2: begin
        has_result    = 1'b1;
        result.kind   = (rx_byte == sum_high) ? KIND_GOOD : KIND_BAD;
        sum_low_next  = SUM_START;
        sum_high_next = SUM_START;
        phase_next    = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      frame_class   <= 8'd0;
      frame_id      <= 8'd0;
      frame_length  <= 8'd0;
      payload_count <= 8'd0;
      sum_low       <= SUM_START;
      sum_high      <= SUM_START;
    end else if (step) begin
      phase         <= phase_next;
      frame_class   <= frame_class_next;
      frame_id      <= frame_id_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      sum_low       <= sum_low_next;
      sum_high      <= sum_high_next;
    end
  end

endmodule

// ----- hw/rtl/sync_framed_packet_parser_fletcher_top.sv -----
// Path: a byte reaches the input register on acceptance and its result, if any, is
// captured in the output register, raising out_valid, when the parser steps on that byte.
// Throughput: one byte per cycle unless a result waits on a full, stalled output slot.
// Reset (rst, synchronous): hunt for the first sync byte, sums 0xFF, header fields
// zero, sync registers 0xC2 and 0x53, both stages empty.
// Top level: config registers, input register, parser and output register.
module sync_framed_packet_parser_fletcher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] class_code,
  output logic [7:0] msg_id,
  output logic [7:0] payload_len,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index
);
  import sfpp_pkg::*;

  logic [7:0] sync_first, sync_second;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       has_result;
  result_t    result;
  result_t    out_reg;
  logic       step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC1_RESET;
      sync_second <= SYNC2_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held byte unless it yields a result and the output slot is still full
  assign step     = hold_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

  sfpp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (hold_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .has_result  (has_result),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_reg <= result;
    end
  end

  assign kind          = out_reg.kind;
  assign class_code    = out_reg.class_code;
  assign msg_id        = out_reg.msg_id;
  assign payload_len   = out_reg.payload_len;
  assign payload_byte  = out_reg.payload_byte;
  assign payload_index = out_reg.payload_index;

endmodule

// ----- tb/tb_sync_framed_packet_parser_fletcher_top.sv -----
// Self-checking bench for the sync-framed packet parser with its mod-255 frame check.
// Needs sfpp_pkg and sync_framed_packet_parser_fletcher_top; a scoreboard class predicts
// every result beat, and plain tasks feed bytes, write the sync registers and drain.
module tb_sync_framed_packet_parser_fletcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpp_pkg::*;

  localparam int   CYCLE_LIMIT     = 200000;

  typedef enum {FRAME_INTACT, FRAME_BAD_FIRST, FRAME_BAD_SECOND} frame_fault_t;

  class parser_scoreboard;
    logic [7:0] sync_a, sync_b;
    logic [2:0] phase;
    logic [7:0] cls, id, len, count, lo, hi;
    result_t    awaited_results[$];
    int         errors, useful, payload_beats, good_frames, bad_frames;

    function new();
      sync_a = SYNC1_RESET;
      sync_b = SYNC2_RESET;
      phase  = PH_SYNC1;
      cls    = '0;
      id     = '0;
      len    = '0;
      count  = '0;
      lo     = SUM_START;
      hi     = SUM_START;
    endfunction

    // Fold one byte into the pair {high, low}, each kept mod 255
    static function logic [15:0] fold_sums(logic [15:0] s, logic [7:0] b);
      logic [8:0] l, h;
      l = {1'b0, s[7:0]} + {1'b0, b};
      if (l > 9'd255) l = l - 9'd255;
      h = {1'b0, s[15:8]} + {1'b0, l[7:0]};
      if (h > 9'd255) h = h - 9'd255;
      return {h[7:0], l[7:0]};
    endfunction

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == CFG_SYNC_FIRST) sync_a = v;
      else sync_b = v;
    endfunction

    function void await_result(logic [1:0] k, logic [7:0] pb, logic [7:0] pi);
      result_t r;
      r.kind          = k;
      r.class_code    = cls;
      r.msg_id        = id;
      r.payload_len   = len;
      r.payload_byte  = pb;
      r.payload_index = pi;
      awaited_results.push_back(r);
      if (k == KIND_PAYLOAD) payload_beats++;
      else if (k == KIND_GOOD) good_frames++;
      else bad_frames++;
    endfunction

    function void restart_sums();
      lo = SUM_START;
      hi = SUM_START;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] idx;
      if (!(phase == PH_SYNC1 && b != sync_a)) useful++;
      case (phase)
        PH_SYNC1: begin
          if (b == sync_a) begin
            {hi, lo} = fold_sums({hi, lo}, b);
            phase = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // the second-sync compare takes priority when both registers match
          if (b == sync_b) begin
            {hi, lo} = fold_sums({hi, lo}, b);
            phase = PH_CLASS;
          end else if (b == sync_a) begin
            restart_sums();
            {hi, lo} = fold_sums({hi, lo}, b);
          end else begin
            restart_sums();
            phase = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          cls = b;
          {hi, lo} = fold_sums({hi, lo}, b);
          phase = PH_ID;
        end
        PH_ID: begin
          id = b;
          {hi, lo} = fold_sums({hi, lo}, b);
          phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          len = b;
          {hi, lo} = fold_sums({hi, lo}, b);
          count = '0;
          phase = (b == 8'd0) ? PH_CHK1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          idx = count;
          {hi, lo} = fold_sums({hi, lo}, b);
          count = count + 8'd1;
          if (count == len) begin
            count = '0;
            phase = PH_CHK1;
          end
          await_result(KIND_PAYLOAD, b, idx);
        end
        PH_CHK1: begin
          if (b == lo) begin
            phase = PH_CHK2;
          end else begin
            await_result(KIND_BAD, 8'd0, 8'd0);
            restart_sums();
            phase = PH_SYNC1;
          end
        end
        default: begin
          await_result((b == hi) ? KIND_GOOD : KIND_BAD, 8'd0, 8'd0);
          restart_sums();
          phase = PH_SYNC1;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, actual %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: kind %0d", got.kind);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", {6'd0, want.kind}, {6'd0, got.kind});
      compare_field("class_code", want.class_code, got.class_code);
      compare_field("msg_id", want.msg_id, got.msg_id);
      compare_field("payload_len", want.payload_len, got.payload_len);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] class_code, msg_id, payload_len, payload_byte, payload_index;

  parser_scoreboard sb = new();
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;
  int cycles   = 0;
  int settings = 1;

  sync_framed_packet_parser_fletcher_top uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .class_code(class_code), .msg_id(msg_id), .payload_len(payload_len),
    .payload_byte(payload_byte), .payload_index(payload_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({kind, class_code, msg_id, payload_len, payload_byte, payload_index});
  end

  // Result side: stall a random number of cycles before each beat, calm now and then
  initial begin : result_sink
    int stall, beats;
    beats = 0;
    while (rst) @(posedge clk);
    forever begin
      if (beats % 16 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  // Hold off the sender until every awaited beat has come, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] first_val, input logic [7:0] second_val);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data  <= first_val;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data  <= second_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(CFG_SYNC_FIRST, first_val);
    sb.set_reg(CFG_SYNC_SECOND, second_val);
    settings++;
  endtask

  task automatic send_frame(input bit twice, input logic [7:0] cls, input logic [7:0] id,
                            input logic [7:0] len, input frame_fault_t fault, input int fill);
    logic [7:0]  bytes_q[$];
    logic [15:0] s;
    logic [7:0]  pb, flip;
    s    = {SUM_START, SUM_START};
    flip = 8'($urandom_range(1, 255));
    // a repeated first sync byte reseeds the sums, so fold it only once
    if (twice && sb.sync_a != sb.sync_b) bytes_q.push_back(sb.sync_a);
    bytes_q.push_back(sb.sync_a);
    s = parser_scoreboard::fold_sums(s, sb.sync_a);
    bytes_q.push_back(sb.sync_b);
    s = parser_scoreboard::fold_sums(s, sb.sync_b);
    bytes_q.push_back(cls);
    s = parser_scoreboard::fold_sums(s, cls);
    bytes_q.push_back(id);
    s = parser_scoreboard::fold_sums(s, id);
    bytes_q.push_back(len);
    s = parser_scoreboard::fold_sums(s, len);
    for (int i = 0; i < len; i++) begin
      pb = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      bytes_q.push_back(pb);
      s = parser_scoreboard::fold_sums(s, pb);
    end
    if (fault == FRAME_BAD_FIRST) begin
      bytes_q.push_back(s[7:0] ^ flip);
    end else begin
      bytes_q.push_back(s[7:0]);
      bytes_q.push_back((fault == FRAME_BAD_SECOND) ? (s[15:8] ^ flip) : s[15:8]);
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
  endtask

  // Feed filler until the parser is hunting again
  task automatic resync();
    logic [7:0] b;
    while (sb.phase != PH_SYNC1) begin
      do b = 8'($urandom_range(0, 255)); while (b == sb.sync_a);
      send_byte(b);
    end
  endtask

  task automatic random_unit();
    int           pick, r, n;
    logic [7:0]   len, b;
    frame_fault_t fault;
    in_calm = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      resync();
      r = $urandom_range(0, 99);
      if (r < 60) len = 8'($urandom_range(0, 8));
      else if (r < 90) len = 8'($urandom_range(9, 40));
      else len = 8'($urandom_range(41, 80));
      r = $urandom_range(0, 9);
      if (r < 6) fault = FRAME_INTACT;
      else if (r < 8) fault = FRAME_BAD_FIRST;
      else fault = FRAME_BAD_SECOND;
      send_frame($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), len, fault, -1);
    end else if (pick < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        b = ($urandom_range(0, 3) == 0) ? sb.sync_a : 8'($urandom_range(0, 255));
        send_byte(b);
      end
    end else begin
      // broken opening: wrong second sync byte, or a frame cut off within or just after its header
      resync();
      send_byte(sb.sync_a);
      if ($urandom_range(0, 1) == 0) begin
        do b = 8'($urandom_range(0, 255)); while (b == sb.sync_a || b == sb.sync_b);
        send_byte(b);
      end else begin
        send_byte(sb.sync_b);
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  task automatic random_phase(input int n);
    int goal;
    goal = sb.useful + n;
    while (sb.useful < goal) random_unit();
  endtask

  initial begin : stimulus
    logic [7:0] a, b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, repeated sync, wrong second sync, extremes, both check failures
    in_calm = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b1, 8'h00, 8'hFF, 8'd0, FRAME_INTACT, -1);
    send_byte(sb.sync_a);
    send_byte(8'h12);
    send_frame(1'b0, 8'hFF, 8'h00, 8'd1, FRAME_BAD_SECOND, 255);
    send_frame(1'b0, 8'h01, 8'h02, 8'd0, FRAME_BAD_FIRST, -1);

    random_phase(180);
    drain();
    write_regs(8'h00, 8'hFF);
    random_phase(180);
    drain();
    write_regs(8'hFF, 8'h00);
    resync();
    send_frame(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255,
               FRAME_INTACT, -1);
    random_phase(180);
    drain();
    write_regs(8'h5A, 8'h5A);
    random_phase(180);
    drain();
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    write_regs(a, b);
    random_phase(180);
    drain();

    if (sb.awaited_results.size() != 0) begin
      $error("%0d result beats never arrived", sb.awaited_results.size());
      sb.errors++;
    end
    $display("Fed %0d parsed bytes under %0d sync settings, including a 255-byte payload.",
             sb.useful, settings);
    $display("Predicted %0d payload beats, %0d good frames and %0d bad frames.",
             sb.payload_beats, sb.good_frames, sb.bad_frames);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
